>>> rtl/ssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment shift driver package
// Operation codes, frame layout constants, the glyph table and shared types.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int unsigned DigitCount = 4;
  localparam int unsigned DigitBits  = 7;
  localparam int unsigned MaskBits   = DigitCount + 1;
  localparam int unsigned FrameBits  = 32;
  localparam int unsigned DotsPos    = DigitCount * DigitBits;
  localparam int unsigned BitCntW    = $clog2(FrameBits);

  typedef logic [DigitBits-1:0] segments_t;
  typedef logic [FrameBits-1:0] frame_t;
  typedef logic [MaskBits-1:0]  mask_t;

  typedef enum logic [2:0] {
    OP_SET_DIGIT   = 3'd0,
    OP_SET_DOTS    = 3'd1,
    OP_TOGGLE_DOTS = 3'd2,
    OP_SET_MASK    = 3'd3,
    OP_TOGGLE_MASK = 3'd4,
    OP_REFRESH     = 3'd5
  } op_e;

  typedef enum logic {
    SHIFT_IDLE,
    SHIFT_BUSY
  } shift_state_e;

  // Status of the frame queue as seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Segment pattern for a glyph code; bit 0 is segment A, bit 6 segment G.
  // Codes outside the table, the blank code included, give all segments off.
  function automatic segments_t glyph_lookup(logic [7:0] code);
    segments_t seg;
    case (code)
      8'd0:    seg = 7'b0111111;
      8'd1:    seg = 7'b0000110;
      8'd2:    seg = 7'b1011011;
      8'd3:    seg = 7'b1001111;
      8'd4:    seg = 7'b1100110;
      8'd5:    seg = 7'b1101101;
      8'd6:    seg = 7'b1111101;
      8'd7:    seg = 7'b0000111;
      8'd8:    seg = 7'b1111111;
      8'd9:    seg = 7'b1101111;
      8'd10:   seg = 7'b1010000;
      8'd11:   seg = 7'b1110111;
      8'd12:   seg = 7'b1010100;
      8'd13:   seg = 7'b1011110;
      8'd14:   seg = 7'b0011100;
      8'd15:   seg = 7'b1111001;
      8'd16:   seg = 7'b1101101;
      8'd17:   seg = 7'b1011100;
      8'd18:   seg = 7'b1110001;
      8'd19:   seg = 7'b0111110;
      8'd20:   seg = 7'b1111100;
      8'd21:   seg = 7'b1111000;
      8'd22:   seg = 7'b0000001;
      8'd23:   seg = 7'b0000010;
      8'd24:   seg = 7'b0000100;
      8'd25:   seg = 7'b0001000;
      8'd26:   seg = 7'b0010000;
      8'd27:   seg = 7'b0100000;
      8'd28:   seg = 7'b1110110;
      8'd29:   seg = 7'b0110000;
      8'd30:   seg = 7'b1011111;
      8'd31:   seg = 7'b0010000;
      8'd32:   seg = 7'b1101110;
      8'd33:   seg = 7'b1110100;
      8'd34:   seg = 7'b1000000;
      default: seg = '0;
    endcase
    return seg;
  endfunction

endpackage

>>> rtl/ssd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment shift driver channels
// Valid/ready channels for operation transactions and for frame bits.
// ----------------------------------------------------------------------------
interface ssd_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [1:0] digit_index;
  logic [7:0] glyph_code;
  logic       dots_value;
  logic [4:0] mask_value;

  modport source (output valid, operation, digit_index, glyph_code, dots_value,
                  mask_value, input ready);
  modport sink (input valid, operation, digit_index, glyph_code, dots_value,
                mask_value, output ready);
endinterface

interface ssd_out_if;
  logic valid;
  logic ready;
  logic serial_bit;
  logic last_bit;

  modport source (output valid, serial_bit, last_bit, input ready);
  modport sink (input valid, serial_bit, last_bit, output ready);
endinterface

>>> rtl/ssd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment shift driver front end
// Accepts operations, updates the display state and queues refresh frames.
// ----------------------------------------------------------------------------
module ssd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ssd_in_if.sink               in_i,
  input  ssd_pkg::queue_status_t status_i,
  output logic                 push_o,
  output ssd_pkg::frame_t      frame_o
);

  ssd_pkg::segments_t digit_q [ssd_pkg::DigitCount];
  ssd_pkg::segments_t digit_d [ssd_pkg::DigitCount];
  logic               dots_q, dots_d;
  ssd_pkg::mask_t     mask_q, mask_d;
  logic               is_refresh;
  logic               accept;

  assign is_refresh = (in_i.operation == ssd_pkg::OP_REFRESH);
  assign in_i.ready = !is_refresh || !status_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = accept && is_refresh;

  always_comb begin
    frame_o = '0;
    for (int k = 0; k < ssd_pkg::DigitCount; k++) begin
      frame_o[k*ssd_pkg::DigitBits +: ssd_pkg::DigitBits] =
        digit_q[k] & {ssd_pkg::DigitBits{mask_q[k]}};
    end
    frame_o[ssd_pkg::DotsPos] = dots_q & mask_q[ssd_pkg::DigitCount];
  end

  always_comb begin
    digit_d = digit_q;
    dots_d  = dots_q;
    mask_d  = mask_q;
    if (accept) begin
      case (in_i.operation)
        ssd_pkg::OP_SET_DIGIT:   digit_d[in_i.digit_index] =
                                   ssd_pkg::glyph_lookup(in_i.glyph_code);
        ssd_pkg::OP_SET_DOTS:    dots_d = in_i.dots_value;
        ssd_pkg::OP_TOGGLE_DOTS: dots_d = !dots_q;
        ssd_pkg::OP_SET_MASK:    mask_d = in_i.mask_value;
        ssd_pkg::OP_TOGGLE_MASK: mask_d = mask_q ^ in_i.mask_value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ssd_pkg::DigitCount; k++) digit_q[k] <= '0;
      dots_q <= 1'b0;
      mask_q <= '1;
    end else begin
      digit_q <= digit_d;
      dots_q  <= dots_d;
      mask_q  <= mask_d;
    end
  end

endmodule

>>> rtl/ssd_frame_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment shift driver frame queue
// Small first-in first-out queue of packed frames between front and back.
// ----------------------------------------------------------------------------
module ssd_frame_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  ssd_pkg::frame_t        frame_i,
  input  logic                   pop_i,
  output ssd_pkg::frame_t        frame_o,
  output ssd_pkg::queue_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ssd_pkg::frame_t     entry_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign frame_o        = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= frame_i;
    end
  end

endmodule

>>> rtl/ssd_shifter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment shift driver back end
// Takes frames from the queue and shifts them out, most significant bit first.
// ----------------------------------------------------------------------------
module ssd_shifter (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ssd_pkg::queue_status_t status_i,
  input  ssd_pkg::frame_t        frame_i,
  output logic                   pop_o,
  ssd_out_if.source              out_o
);

  ssd_pkg::shift_state_e          state_q, state_d;
  ssd_pkg::frame_t                shift_q, shift_d;
  logic [ssd_pkg::BitCntW-1:0]    cnt_q, cnt_d;
  logic                           last;
  logic                           accept;

  assign last           = (cnt_q == ssd_pkg::BitCntW'(ssd_pkg::FrameBits - 1));
  assign accept         = out_o.valid && out_o.ready;
  assign out_o.serial_bit = shift_q[ssd_pkg::FrameBits-1];
  assign out_o.last_bit   = last;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ssd_pkg::SHIFT_IDLE: begin
        if (!status_i.empty) state_d = ssd_pkg::SHIFT_BUSY;
      end
      ssd_pkg::SHIFT_BUSY: begin
        if (accept && last && status_i.empty) state_d = ssd_pkg::SHIFT_IDLE;
      end
      default: state_d = ssd_pkg::SHIFT_IDLE;
    endcase
  end

  always_comb begin
    out_o.valid = 1'b0;
    pop_o       = 1'b0;
    case (state_q)
      ssd_pkg::SHIFT_IDLE: begin
        pop_o = !status_i.empty;
      end
      ssd_pkg::SHIFT_BUSY: begin
        out_o.valid = 1'b1;
        pop_o       = accept && last && !status_i.empty;
      end
      default: ;
    endcase
  end

  always_comb begin
    shift_d = shift_q;
    cnt_d   = cnt_q;
    if (pop_o) begin
      shift_d = frame_i;
      cnt_d   = '0;
    end else if (accept) begin
      shift_d = {shift_q[ssd_pkg::FrameBits-2:0], 1'b0};
      cnt_d   = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssd_pkg::SHIFT_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

endmodule

>>> rtl/seven_segment_shift_driver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment shift driver core
// Keeps four digits, the dots and a visibility mask, and serialises refresh
// frames for a chain of display shift registers.
// ----------------------------------------------------------------------------
// Register operations are accepted every cycle.
// A refresh puts out 32 bits, one per cycle while the output is ready; with the
// shifter idle the frame is first written into the frame queue and then popped by
// the shifter as it enters its busy state, where it offers the first bit, and the
// shifter sets the sustained refresh rate once the frame queue is full. Reset
// clears the digits and dots, sets the mask to all ones and empties the queue.
module seven_segment_shift_driver_core #(
  parameter int unsigned FRAME_QUEUE_DEPTH = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  ssd_in_if.sink    in_i,
  ssd_out_if.source out_o
);

  ssd_pkg::queue_status_t status;
  ssd_pkg::frame_t        push_frame;
  ssd_pkg::frame_t        head_frame;
  logic                   push;
  logic                   pop;

  ssd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .status_i (status),
    .push_o   (push),
    .frame_o  (push_frame)
  );

  ssd_frame_queue #(
    .Depth (FRAME_QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .frame_i  (push_frame),
    .pop_i    (pop),
    .frame_o  (head_frame),
    .status_o (status)
  );

  ssd_shifter u_shifter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .frame_i  (head_frame),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule

>>> rtl/ssd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment shift driver checker
// Port-level properties of the core, attached to it by a bind statement.
// ----------------------------------------------------------------------------
module ssd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [2:0] in_operation_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_serial_bit_i,
  input logic       out_last_bit_i
);

  // Operations other than a refresh never wait.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && (in_operation_i != ssd_pkg::OP_REFRESH) |-> in_ready_i)
    else $error("non-refresh transaction stalled");

  // Once a frame has started, its bits follow without a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_bit_i |=> out_valid_i)
    else $error("frame interrupted before its last bit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_serial_bit_i) && $stable(out_last_bit_i))
    else $error("output payload changed while stalled");

endmodule

bind seven_segment_shift_driver_core ssd_checker u_ssd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_operation_i   (in_i.operation),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_serial_bit_i (out_o.serial_bit),
  .out_last_bit_i   (out_o.last_bit)
);
